FILE: sv/cfft_pkg.sv
package cfft_pkg;

  // Fixed field widths of the request and result items
  localparam int unsigned REQ_W      = 3;
  localparam int unsigned BUCKET_W   = 10;
  localparam int unsigned SLOT_W     = 2;
  localparam int unsigned TAG_W      = 63;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned TAG_BITS_W = 6;
  localparam int unsigned LOG2_W     = 4;
  localparam int unsigned S_TDATA_W  = 88;
  localparam int unsigned M_TDATA_W  = 128;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BKT_LOG2 = 1'b1;

  localparam logic [TAG_BITS_W-1:0] TAG_BITS_RST = 6'd16;
  localparam logic [LOG2_W-1:0]     BKT_LOG2_RST = 4'd10;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_FIND1  = 3'd2,
    REQ_FIND2  = 3'd3,
    REQ_READ   = 3'd4,
    REQ_WRITE  = 3'd5
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BKT_OOR  = 2'd1,
    ST_SLOT_OOR = 2'd2,
    ST_TAG_WIDE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_RD_A,
    CS_RD_B,
    CS_EXEC
  } ctrl_state_e;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [BUCKET_W-1:0] bucket;
    logic [BUCKET_W-1:0] alt_bucket;
    logic [SLOT_W-1:0]   slot;
    logic [TAG_W-1:0]    tag_value;
    logic                kickout;
    logic [SLOT_W-1:0]   victim_slot;
  } req_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_en;
    logic take_req;
    logic rd_en;
    logic rd_alt;
    logic hold_a;
    logic exec_en;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic find_two;
    logic out_busy;
  } ctrl_sts_t;

endpackage

FILE: sv/cuckoo_filter_tag_table_unit.sv
// Sequence: an accepted item reads bucket A, then bucket B for find-two only,
//   then executes into the result register; no new item is taken until then.
//   The bucket read is registered, and the execute step also writes back.
//   A result item still waiting downstream holds the execute cycle.
// Reset: async active low; a clearing pass then zeroes one bucket per cycle
//   until all BUCKET_CNT buckets are clear, and no item is accepted until it is done.
module cuckoo_filter_tag_table_unit #(
  parameter int unsigned BUCKET_CNT       = 1024,
  parameter int unsigned SLOTS_PER_BUCKET = 4,
  parameter int unsigned MAX_TAG_WIDTH    = 63
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write port
  input  logic                               cfg_we_i,
  input  logic [cfft_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [cfft_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // request items
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // bucket[9:0], alt_bucket[19:10], slot[21:20], tag_value[84:22],
  // kickout[85], victim_slot[87:86]
  input  logic [cfft_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // req_type[2:0]
  input  logic [cfft_pkg::REQ_W-1:0]         s_axis_tuser_i,
  // result items
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // hit[0], evicted_valid[1], evicted_tag[64:2], read_value[127:65]
  output logic [cfft_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  // status[1:0]
  output logic [cfft_pkg::STATUS_W-1:0]      m_axis_tuser_o
);
  import cfft_pkg::*;

  ctrl_cmd_t        cmd;
  ctrl_sts_t        sts;
  req_t             req;
  logic             hit, ev_valid;
  logic [TAG_W-1:0] ev_tag, rd_val;

  // unpack the request item
  assign req.req_type    = s_axis_tuser_i;
  assign req.bucket      = s_axis_tdata_i[9:0];
  assign req.alt_bucket  = s_axis_tdata_i[19:10];
  assign req.slot        = s_axis_tdata_i[21:20];
  assign req.tag_value   = s_axis_tdata_i[84:22];
  assign req.kickout     = s_axis_tdata_i[85];
  assign req.victim_slot = s_axis_tdata_i[87:86];

  // sequencer: clear pass, then accept / read A / (read B) / execute
  cfft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // bucket memory, checks, slot compare and result register
  cfft_dp #(
    .BUCKET_CNT       (BUCKET_CNT),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
    .MAX_TAG_WIDTH    (MAX_TAG_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_i           (req),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .status_o        (m_axis_tuser_o),
    .hit_o           (hit),
    .evicted_valid_o (ev_valid),
    .evicted_tag_o   (ev_tag),
    .read_value_o    (rd_val),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

  assign m_axis_tdata_o = {rd_val, ev_tag, ev_valid, hit};

`ifndef SYNTHESIS
  // no item taken while the clearing pass runs
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_en |-> !s_axis_tready_o)
    else $error("item accepted during clearing pass");

  // execute never overwrites a result still waiting
  a_exec_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec_en |-> !sts.out_busy)
    else $error("result overwritten before taken");

  // execute always presents a result next cycle
  a_exec_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec_en |=> m_axis_tvalid_o)
    else $error("execute without result");

  // a bucket read always lies between accept and execute
  a_read_before_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (cmd.rd_en && !cmd.exec_en))
    else $error("bucket not read after accept");
`endif

endmodule

FILE: sv/cfft_ram.sv
module cfft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/cfft_ctrl.sv
module cfft_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cfft_pkg::ctrl_sts_t sts_i,
  output cfft_pkg::ctrl_cmd_t cmd_o
);
  import cfft_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      CS_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) state_d = CS_IDLE;
      end
      CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_req = 1'b1;
          state_d        = CS_RD_A;
        end
      end
      CS_RD_A: begin
        cmd_o.rd_en = 1'b1;
        state_d     = sts_i.find_two ? CS_RD_B : CS_EXEC;
      end
      CS_RD_B: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_alt = 1'b1;
        cmd_o.hold_a = 1'b1;
        state_d      = CS_EXEC;
      end
      CS_EXEC: begin
        if (!sts_i.out_busy) begin
          cmd_o.exec_en = 1'b1;
          state_d       = CS_IDLE;
        end
      end
      default: state_d = CS_CLEAR;
    endcase
  end

endmodule

FILE: sv/cfft_dp.sv
module cfft_dp #(
  parameter int unsigned BUCKET_CNT       = 1024,
  parameter int unsigned SLOTS_PER_BUCKET = 4,
  parameter int unsigned MAX_TAG_WIDTH    = 63
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // config
  input  logic                                  cfg_we_i,
  input  logic [cfft_pkg::CFG_IDX_W-1:0]        cfg_addr_i,
  input  logic [cfft_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  // request capture
  input  cfft_pkg::req_t                        req_i,
  // result
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [cfft_pkg::STATUS_W-1:0]         status_o,
  output logic                                  hit_o,
  output logic                                  evicted_valid_o,
  output logic [cfft_pkg::TAG_W-1:0]            evicted_tag_o,
  output logic [cfft_pkg::TAG_W-1:0]            read_value_o,
  // control
  input  cfft_pkg::ctrl_cmd_t                   cmd_i,
  output cfft_pkg::ctrl_sts_t                   sts_o
);
  import cfft_pkg::*;

  localparam int unsigned BktAw = (BUCKET_CNT > 1) ? $clog2(BUCKET_CNT) : 1;
  localparam int unsigned SlotW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int unsigned Tw    = MAX_TAG_WIDTH;
  localparam int unsigned RowW  = SLOTS_PER_BUCKET * MAX_TAG_WIDTH;

  // config registers
  logic [TAG_BITS_W-1:0] tag_bits_q;
  logic [LOG2_W-1:0]     bkt_log2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_bits_q <= TAG_BITS_RST;
      bkt_log2_q <= BKT_LOG2_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_TAG_BITS: tag_bits_q <= cfg_wdata_i[TAG_BITS_W-1:0];
        CFG_BKT_LOG2: bkt_log2_q <= cfg_wdata_i[LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  // request register
  req_t req_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_req) req_q <= req_i;
  end

  // range and width checks, registered while bucket A is read
  logic                  bkt_oor, alt_oor, slot_oor, too_wide;
  logic [TAG_BITS_W-1:0] eff_w;
  logic [63:0]           keep_mask;
  logic [3:0]            slot4;
  logic                  known_req, is_rd, is_wr;
  logic [STATUS_W-1:0]   status_d, status_q;

  assign known_req = (req_q.req_type <= REQ_WRITE);
  assign is_rd     = (req_q.req_type == REQ_READ);
  assign is_wr     = (req_q.req_type == REQ_WRITE);
  assign slot4     = {2'b00, req_q.slot};

  always_comb begin
    bkt_oor   = ((req_q.bucket >> bkt_log2_q) != '0) ||
                ({11'd0, req_q.bucket} >= 21'(BUCKET_CNT));
    alt_oor   = ((req_q.alt_bucket >> bkt_log2_q) != '0) ||
                ({11'd0, req_q.alt_bucket} >= 21'(BUCKET_CNT));
    slot_oor  = (slot4 >= 4'(SLOTS_PER_BUCKET));
    eff_w     = (tag_bits_q > TAG_BITS_W'(MAX_TAG_WIDTH)) ?
                TAG_BITS_W'(MAX_TAG_WIDTH) : tag_bits_q;
    keep_mask = (64'd1 << eff_w) - 64'd1;
    too_wide  = |(req_q.tag_value & ~keep_mask[TAG_W-1:0]);

    status_d = ST_OK;
    if (known_req) begin
      if (bkt_oor || (req_q.req_type == REQ_FIND2 && alt_oor)) begin
        status_d = ST_BKT_OOR;
      end else if ((is_rd || is_wr) && slot_oor) begin
        status_d = ST_SLOT_OOR;
      end else if (!is_rd && too_wide) begin
        status_d = ST_TAG_WIDE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en && !cmd_i.rd_alt) status_q <= status_d;
  end

  // clearing pass counter
  logic [BktAw-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= clr_cnt_q + BktAw'(1);
    end
  end

  // bucket addresses
  logic [19:0]      bkt_wide, alt_wide;
  logic [BktAw-1:0] bkt_addr, alt_addr, raddr, waddr;

  assign bkt_wide = {10'd0, req_q.bucket};
  assign alt_wide = {10'd0, req_q.alt_bucket};
  assign bkt_addr = bkt_wide[BktAw-1:0];
  assign alt_addr = alt_wide[BktAw-1:0];
  assign raddr    = cmd_i.rd_alt ? alt_addr : bkt_addr;

  // bucket memory, one row per bucket
  logic            ram_we;
  logic [RowW-1:0] ram_wdata, rdata, new_row;

  cfft_ram #(
    .Width (RowW),
    .Depth (BUCKET_CNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // per-slot compare
  logic [Tw-1:0]               lane [SLOTS_PER_BUCKET];
  logic [SLOTS_PER_BUCKET-1:0] is_empty, is_match;
  logic [SlotW-1:0]            empty_idx, match_idx, slot_idx, victim_idx;
  logic [3:0]                  victim4;
  logic [3:0]                  slot_full;

  always_comb begin
    for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
      lane[i]     = rdata[i*Tw +: Tw];
      is_empty[i] = (lane[i] == '0);
      is_match[i] = (TAG_W'(lane[i]) == req_q.tag_value);
    end
    empty_idx = '0;
    match_idx = '0;
    for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--) begin
      if (is_empty[i]) empty_idx = SlotW'(i);
      if (is_match[i]) match_idx = SlotW'(i);
    end
    // victim modulo slot count, value below four
    victim4 = {2'b00, req_q.victim_slot};
    for (int k = 0; k < 3; k++) begin
      if (victim4 >= 4'(SLOTS_PER_BUCKET)) victim4 = victim4 - 4'(SLOTS_PER_BUCKET);
    end
    slot_full  = slot4;
    victim_idx = victim4[SlotW-1:0];
    slot_idx   = slot_full[SlotW-1:0];
  end

  // bucket A match for find-two, sampled when its row arrives
  logic hit_a_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_a) hit_a_q <= |is_match;
  end

  // execute
  logic             row_we, ex_hit, ex_ev_valid;
  logic [TAG_W-1:0] ex_ev_tag, ex_rd;
  logic [Tw-1:0]    tag_st;

  assign tag_st = req_q.tag_value[Tw-1:0];

  always_comb begin
    new_row     = rdata;
    row_we      = 1'b0;
    ex_hit      = 1'b0;
    ex_ev_valid = 1'b0;
    ex_ev_tag   = '0;
    ex_rd       = '0;
    if (status_q == ST_OK) begin
      case (req_q.req_type)
        REQ_INSERT: begin
          if (|is_empty) begin
            new_row[empty_idx*Tw +: Tw] = tag_st;
            row_we = 1'b1;
            ex_hit = 1'b1;
          end else if (req_q.kickout) begin
            new_row[victim_idx*Tw +: Tw] = tag_st;
            row_we      = 1'b1;
            ex_ev_valid = 1'b1;
            ex_ev_tag   = TAG_W'(lane[victim_idx]);
          end
        end
        REQ_DELETE: begin
          if (|is_match) begin
            new_row[match_idx*Tw +: Tw] = '0;
            row_we = 1'b1;
            ex_hit = 1'b1;
          end
        end
        REQ_FIND1: ex_hit = |is_match;
        REQ_FIND2: ex_hit = hit_a_q | (|is_match);
        REQ_READ:  ex_rd  = TAG_W'(lane[slot_idx]);
        REQ_WRITE: begin
          new_row[slot_idx*Tw +: Tw] = tag_st;
          row_we = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign ram_we    = cmd_i.clr_en | (cmd_i.exec_en & row_we);
  assign waddr     = cmd_i.clr_en ? clr_cnt_q : bkt_addr;
  assign ram_wdata = cmd_i.clr_en ? '0 : new_row;

  // result register
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic                out_hit_q, out_ev_valid_q;
  logic [TAG_W-1:0]    out_ev_tag_q, out_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_en) begin
      out_status_q   <= status_q;
      out_hit_q      <= ex_hit;
      out_ev_valid_q <= ex_ev_valid;
      out_ev_tag_q   <= ex_ev_tag;
      out_rd_q       <= ex_rd;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign hit_o           = out_hit_q;
  assign evicted_valid_o = out_ev_valid_q;
  assign evicted_tag_o   = out_ev_tag_q;
  assign read_value_o    = out_rd_q;

  assign sts_o.clr_last = (clr_cnt_q == BktAw'(BUCKET_CNT - 1));
  assign sts_o.find_two = (req_q.req_type == REQ_FIND2);
  assign sts_o.out_busy = out_valid_q & ~out_ready_i;

endmodule

FILE: tb/cuckoo_filter_tag_table_unit_tb.sv
module cuckoo_filter_tag_table_unit_tb;
  import cfft_pkg::*;

  // Table geometry, matched to the instance below
  localparam int unsigned NUM_BKT = 1024;
  localparam int unsigned SLOTS   = 4;

  // Request codes the block must ignore (result item all zero)
  localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

  localparam logic [TAG_W-1:0] TAG_ALL_SET = '1;

  // Cycles to let pass once nothing is outstanding
  localparam int unsigned DRAIN_CYCLES = 10;
  // Long receiver hold-off that backs the block up into its input
  localparam int unsigned HOLD_CYCLES  = 400;

  localparam int unsigned NUM_PHASES     = 9;
  localparam int unsigned ITEMS_PER_PHASE = 150;

  // One result item, unpacked from tuser/tdata
  typedef struct packed {
    status_e          status;
    logic             hit;
    logic             ev_valid;
    logic [TAG_W-1:0] ev_tag;
    logic [TAG_W-1:0] rd_tag;
  } table_res_t;

  // Row of the directed table: either a register setting or one request item
  typedef struct {
    bit                  is_cfg;
    logic [TAG_BITS_W-1:0] tbits;
    logic [LOG2_W-1:0]   lg2;
    req_t                item;
    bit                  has_want;
    table_res_t          want;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block-facing signals (the driven ones start at known values)
  // ---------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr  = CFG_TAG_BITS;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;
  logic [REQ_W-1:0]       s_tuser = '0;

  logic                   m_valid;
  logic                   rx_ready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic [STATUS_W-1:0]    m_tuser;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  cuckoo_filter_tag_table_unit #(
    .BUCKET_CNT       (NUM_BKT),
    .SLOTS_PER_BUCKET (SLOTS),
    .MAX_TAG_WIDTH    (TAG_W)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (rx_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // ---------------------------------------------------------------------------
  // Mirror of the bucket table and its two registers
  // ---------------------------------------------------------------------------
  logic [TAG_W-1:0]      tag_mirror [NUM_BKT*SLOTS];
  logic [TAG_BITS_W-1:0] mirror_tag_bits = TAG_BITS_RST;
  logic [LOG2_W-1:0]     mirror_log2     = BKT_LOG2_RST;

  table_res_t pending_outcomes [$];

  // Run bookkeeping
  int unsigned mismatch_cnt  = 0;
  int unsigned items_sent    = 0;
  int unsigned evictions     = 0;
  int unsigned find_hits     = 0;
  int unsigned error_items   = 0;
  int unsigned settings_used = 0;

  // Sender / receiver pacing
  int unsigned burst_left   = 0;
  bit          sender_eager = 1'b0;
  bit          rx_hold_req  = 1'b0;
  int unsigned rx_cycle     = 0;

  // Random-part shaping: a few hot buckets and a small tag pool per phase,
  // so buckets actually fill, evict, and deletes/finds find something.
  logic [BUCKET_W-1:0] hot_bkts [4];
  logic [TAG_W-1:0]    tag_pool [8];

  // Tags may only use the low tag_bits bits; 63 or more opens the full width
  function automatic logic [TAG_W-1:0] width_mask(input logic [TAG_BITS_W-1:0] bits);
    return (bits >= 6'd63) ? TAG_ALL_SET : ((63'd1 << bits) - 63'd1);
  endfunction

  function automatic int unsigned live_buckets();
    return (mirror_log2 >= 4'd10) ? NUM_BKT : (32'd1 << mirror_log2);
  endfunction

  // Apply one request to the mirror and return the result item it yields
  function automatic table_res_t bucket_table_apply(input req_t r);
    table_res_t  res;
    int unsigned nb;
    int unsigned base;
    int unsigned alt_base;
    int unsigned vic;
    bit          done;
    res      = '0;
    res.status = ST_OK;
    nb       = live_buckets();
    base     = r.bucket * SLOTS;
    alt_base = r.alt_bucket * SLOTS;
    done     = 1'b0;

    // reserved codes: table untouched, result all zero
    if (r.req_type > REQ_WRITE) return res;

    // bucket range first (both buckets on find-two), then tag width;
    // the 2-bit slot can never leave a 4-slot bucket
    if (r.bucket >= nb || (r.req_type == REQ_FIND2 && r.alt_bucket >= nb)) begin
      res.status = ST_BKT_OOR;
      return res;
    end
    if (r.req_type != REQ_READ && (r.tag_value & ~width_mask(mirror_tag_bits)) != '0) begin
      res.status = ST_TAG_WIDE;
      return res;
    end

    case (r.req_type)
      REQ_INSERT: begin
        // first empty slot; a zero tag "fills" it with zero
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && tag_mirror[base+i] == '0) begin
            tag_mirror[base+i] = r.tag_value;
            res.hit = 1'b1;
            done    = 1'b1;
          end
        end
        if (!done && r.kickout) begin
          vic          = r.victim_slot % SLOTS;
          res.ev_valid = 1'b1;
          res.ev_tag   = tag_mirror[base+vic];
          tag_mirror[base+vic] = r.tag_value;
        end
      end
      REQ_DELETE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && tag_mirror[base+i] == r.tag_value) begin
            tag_mirror[base+i] = '0;
            res.hit = 1'b1;
            done    = 1'b1;
          end
        end
      end
      REQ_FIND1, REQ_FIND2: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tag_mirror[base+i] == r.tag_value) res.hit = 1'b1;
          if (r.req_type == REQ_FIND2 && tag_mirror[alt_base+i] == r.tag_value)
            res.hit = 1'b1;
        end
      end
      REQ_READ:  res.rd_tag = tag_mirror[base+r.slot];
      REQ_WRITE: tag_mirror[base+r.slot] = r.tag_value;
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic dir_row_t mk_item(input logic [REQ_W-1:0] op,
                                       input logic [BUCKET_W-1:0] bkt,
                                       input logic [BUCKET_W-1:0] alt,
                                       input logic [SLOT_W-1:0] slot,
                                       input logic [TAG_W-1:0] tag,
                                       input logic kick,
                                       input logic [SLOT_W-1:0] victim);
    dir_row_t row;
    row = '{default: '0};
    row.item.req_type    = op;
    row.item.bucket      = bkt;
    row.item.alt_bucket  = alt;
    row.item.slot        = slot;
    row.item.tag_value   = tag;
    row.item.kickout     = kick;
    row.item.victim_slot = victim;
    return row;
  endfunction

  function automatic dir_row_t mk_cfg(input logic [TAG_BITS_W-1:0] tbits,
                                      input logic [LOG2_W-1:0] lg2);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.tbits  = tbits;
    row.lg2    = lg2;
    return row;
  endfunction

  // Pin the expected result of a row where it is obvious from the spec
  function automatic dir_row_t with_result(input dir_row_t row, input status_e st,
                                           input logic hit, input logic ev,
                                           input logic [TAG_W-1:0] ev_tag,
                                           input logic [TAG_W-1:0] rd_tag);
    row.has_want      = 1'b1;
    row.want.status   = st;
    row.want.hit      = hit;
    row.want.ev_valid = ev;
    row.want.ev_tag   = ev_tag;
    row.want.rd_tag   = rd_tag;
    return row;
  endfunction

  function automatic req_t draw_request();
    req_t        r;
    int unsigned pick;
    logic [TAG_W-1:0] mask;
    mask          = width_mask(mirror_tag_bits);
    r.slot        = SLOT_W'($urandom_range(0, 3));
    r.kickout     = 1'($urandom_range(0, 1));
    r.victim_slot = SLOT_W'($urandom_range(0, 3));

    pick = $urandom_range(0, 99);
    if (pick < 28)      r.req_type = REQ_INSERT;
    else if (pick < 42) r.req_type = REQ_DELETE;
    else if (pick < 56) r.req_type = REQ_FIND1;
    else if (pick < 72) r.req_type = REQ_FIND2;
    else if (pick < 84) r.req_type = REQ_READ;
    else if (pick < 97) r.req_type = REQ_WRITE;
    else                r.req_type = pick[0] ? REQ_RSVD6 : REQ_RSVD7;

    // mostly hot buckets, some anywhere in range, some possibly out of range
    pick = $urandom_range(0, 99);
    if (pick < 80)      r.bucket = hot_bkts[$urandom_range(0, 3)];
    else if (pick < 92) r.bucket = BUCKET_W'($urandom_range(0, live_buckets() - 1));
    else                r.bucket = BUCKET_W'($urandom_range(0, NUM_BKT - 1));
    pick = $urandom_range(0, 99);
    if (pick < 70) r.alt_bucket = hot_bkts[$urandom_range(0, 3)];
    else           r.alt_bucket = BUCKET_W'($urandom_range(0, NUM_BKT - 1));

    pick = $urandom_range(0, 99);
    if (pick < 65)      r.tag_value = tag_pool[$urandom_range(0, 7)];
    else if (pick < 73) r.tag_value = '0;
    else if (pick < 90) r.tag_value = TAG_W'({$urandom, $urandom}) & mask;
    else                r.tag_value = TAG_W'({$urandom, $urandom});
    return r;
  endfunction

  // Offer one request item; returns once it has been accepted (and, at a
  // burst end or run end, after the sender's gap).
  task automatic offer(input req_t r, input bit has_want, input table_res_t want,
                       input bit end_run);
    table_res_t pred;
    s_valid <= 1'b1;
    s_tdata <= {r.victim_slot, r.kickout, r.tag_value, r.slot, r.alt_bucket, r.bucket};
    s_tuser <= r.req_type;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);

    pred = bucket_table_apply(r);
    pending_outcomes.push_back(has_want ? want : pred);
    items_sent++;
    if (pred.ev_valid) evictions++;
    if (pred.hit && (r.req_type == REQ_FIND1 || r.req_type == REQ_FIND2)) find_hits++;
    if (pred.status != ST_OK) error_items++;

    if (burst_left > 0) burst_left--;
    if (end_run || (burst_left == 0 && !sender_eager)) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Wait until every result item is back and the pipe is quiet
  task automatic settle();
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Both registers, back to back, while the block is idle
  task automatic write_setting(input logic [TAG_BITS_W-1:0] tbits,
                               input logic [LOG2_W-1:0] lg2);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_TAG_BITS;
    cfg_wdata <= tbits;
    @(posedge clk_i);
    cfg_addr  <= CFG_BKT_LOG2;
    cfg_wdata <= {2'b00, lg2};
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    mirror_tag_bits = tbits;
    mirror_log2     = lg2;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: its own stall pattern, cycling through windows of always-ready,
  // coin-flip, mostly-stalled and mostly-ready, chosen by rx_cycle[8:7]. A hold request
  // from the sender side turns into one long hold-off.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_hold_req) begin
        rx_ready    <= 1'b0;
        rx_hold_req  = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        case (rx_cycle[8:7])
          2'd0:    rx_ready <= 1'b1;
          2'd1:    rx_ready <= 1'($urandom_range(0, 1));
          2'd2:    rx_ready <= ($urandom_range(0, 3) == 0);
          default: rx_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every accepted result item against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    table_res_t got;
    table_res_t want;
    if (rst_n && m_valid && rx_ready) begin
      got.status   = status_e'(m_tuser);
      got.hit      = m_tdata[0];
      got.ev_valid = m_tdata[1];
      got.ev_tag   = m_tdata[64:2];
      got.rd_tag   = m_tdata[127:65];
      if (pending_outcomes.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("%0t: result item with nothing outstanding: st=%0d hit=%0d ev=%0d/%h rd=%h",
                   $time, got.status, got.hit, got.ev_valid, got.ev_tag, got.rd_tag);
        mismatch_cnt++;
      end else begin
        want = pending_outcomes.pop_front();
        if (got !== want) begin
          if (mismatch_cnt < 10) begin
            $display("%0t: expected st=%0d hit=%0d ev=%0d/%h rd=%h", $time,
                     want.status, want.hit, want.ev_valid, want.ev_tag, want.rd_tag);
            $display("%0t:   actual st=%0d hit=%0d ev=%0d/%h rd=%h", $time,
                     got.status, got.hit, got.ev_valid, got.ev_tag, got.rd_tag);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t              dir_rows [$];
    bit                    last_of_run;
    logic [TAG_BITS_W-1:0] ph_tbits;
    logic [LOG2_W-1:0]     ph_lg2;

    foreach (tag_mirror[i]) tag_mirror[i] = '0;
    burst_left = $urandom_range(1, 24);

    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;

    // Directed part, reset register values first (tag_bits 16, all buckets)
    dir_rows.push_back(with_result(mk_item(REQ_READ, 10'd0, 10'd0, 2'd0, '0, 1'b0, 2'd0),
                                   ST_OK, 1'b0, 1'b0, '0, '0));
    dir_rows.push_back(with_result(mk_item(REQ_INSERT, 10'd0, 10'd0, 2'd0, 63'hFFFF, 1'b0, 2'd0),
                                   ST_OK, 1'b1, 1'b0, '0, '0));
    // one bit above tag_bits
    dir_rows.push_back(with_result(mk_item(REQ_INSERT, 10'd0, 10'd0, 2'd0, 63'h10000, 1'b1, 2'd0),
                                   ST_TAG_WIDE, 1'b0, 1'b0, '0, '0));
    // zero tag: lands in an empty slot, which stays empty
    dir_rows.push_back(with_result(mk_item(REQ_INSERT, 10'd0, 10'd0, 2'd0, '0, 1'b0, 2'd0),
                                   ST_OK, 1'b1, 1'b0, '0, '0));
    dir_rows.push_back(mk_item(REQ_INSERT, 10'd0, 10'd0, 2'd0, 63'd1, 1'b0, 2'd0));
    dir_rows.push_back(mk_item(REQ_INSERT, 10'd0, 10'd0, 2'd0, 63'd2, 1'b0, 2'd0));
    dir_rows.push_back(mk_item(REQ_INSERT, 10'd0, 10'd0, 2'd0, 63'd3, 1'b0, 2'd0));
    // bucket now full: no kickout means no change and no hit
    dir_rows.push_back(with_result(mk_item(REQ_INSERT, 10'd0, 10'd0, 2'd0, 63'd4, 1'b0, 2'd3),
                                   ST_OK, 1'b0, 1'b0, '0, '0));
    dir_rows.push_back(mk_item(REQ_INSERT, 10'd0, 10'd0, 2'd0, 63'd5, 1'b1, 2'd2));
    dir_rows.push_back(mk_item(REQ_FIND1, 10'd0, 10'd0, 2'd0, 63'd5, 1'b0, 2'd0));
    // zero tag on find-two: hits via the empty alternate bucket
    dir_rows.push_back(mk_item(REQ_FIND2, 10'd0, 10'd1023, 2'd0, '0, 1'b0, 2'd0));
    dir_rows.push_back(mk_item(REQ_DELETE, 10'd0, 10'd0, 2'd0, 63'd1, 1'b0, 2'd0));
    // zero tag on delete: matches the slot just freed
    dir_rows.push_back(mk_item(REQ_DELETE, 10'd0, 10'd0, 2'd0, '0, 1'b0, 2'd0));
    dir_rows.push_back(mk_item(REQ_WRITE, 10'd1023, 10'd0, 2'd3, 63'hABCD, 1'b0, 2'd0));
    dir_rows.push_back(with_result(mk_item(REQ_WRITE, 10'd1023, 10'd0, 2'd2, TAG_ALL_SET, 1'b0,
                                           2'd0),
                                   ST_TAG_WIDE, 1'b0, 1'b0, '0, '0));
    // read ignores the tag field, even an over-wide one
    dir_rows.push_back(mk_item(REQ_READ, 10'd1023, 10'd0, 2'd3, TAG_ALL_SET, 1'b0, 2'd0));
    // reserved request codes with every field at its maximum
    dir_rows.push_back(with_result(mk_item(REQ_RSVD6, '1, '1, '1, TAG_ALL_SET, 1'b1, '1),
                                   ST_OK, 1'b0, 1'b0, '0, '0));
    dir_rows.push_back(with_result(mk_item(REQ_RSVD7, '1, '1, '1, TAG_ALL_SET, 1'b1, '1),
                                   ST_OK, 1'b0, 1'b0, '0, '0));
    // single bucket in use: range checks and their order
    dir_rows.push_back(mk_cfg(6'd16, 4'd0));
    dir_rows.push_back(with_result(mk_item(REQ_INSERT, 10'd1, 10'd0, 2'd0, 63'd1, 1'b0, 2'd0),
                                   ST_BKT_OOR, 1'b0, 1'b0, '0, '0));
    dir_rows.push_back(with_result(mk_item(REQ_FIND2, 10'd0, 10'd1, 2'd0, 63'd1, 1'b0, 2'd0),
                                   ST_BKT_OOR, 1'b0, 1'b0, '0, '0));
    dir_rows.push_back(with_result(mk_item(REQ_FIND2, 10'd0, 10'd0, 2'd0, 63'h10000, 1'b0, 2'd0),
                                   ST_TAG_WIDE, 1'b0, 1'b0, '0, '0));
    dir_rows.push_back(with_result(mk_item(REQ_FIND2, 10'd1023, 10'd0, 2'd0, TAG_ALL_SET, 1'b0,
                                           2'd0),
                                   ST_BKT_OOR, 1'b0, 1'b0, '0, '0));
    // zero-width tags: only zero is legal
    dir_rows.push_back(mk_cfg(6'd0, 4'd4));
    dir_rows.push_back(mk_item(REQ_DELETE, 10'd3, 10'd0, 2'd0, '0, 1'b0, 2'd0));
    dir_rows.push_back(with_result(mk_item(REQ_INSERT, 10'd3, 10'd0, 2'd0, 63'd1, 1'b0, 2'd0),
                                   ST_TAG_WIDE, 1'b0, 1'b0, '0, '0));
    // full width and an over-range bucket count (clamps to the whole table)
    dir_rows.push_back(mk_cfg(6'd63, 4'd15));
    dir_rows.push_back(mk_item(REQ_INSERT, 10'd1023, 10'd0, 2'd0, TAG_ALL_SET, 1'b1, 2'd1));

    for (int i = 0; i < dir_rows.size(); i++) begin
      last_of_run = (i == dir_rows.size() - 1) || dir_rows[i+1].is_cfg;
      if (dir_rows[i].is_cfg) begin
        settle();
        write_setting(dir_rows[i].tbits, dir_rows[i].lg2);
      end else begin
        offer(dir_rows[i].item, dir_rows[i].has_want, dir_rows[i].want, last_of_run);
      end
    end

    // Random part: one register setting per phase, extremes first
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin ph_tbits = 6'd63; ph_lg2 = 4'd15; end
        1:       begin ph_tbits = 6'd1;  ph_lg2 = 4'd0;  end
        2:       begin ph_tbits = 6'd0;  ph_lg2 = 4'd10; end
        3:       begin ph_tbits = 6'd12; ph_lg2 = 4'd1;  end
        default: begin
          ph_tbits = TAG_BITS_W'($urandom_range(0, 63));
          ph_lg2   = LOG2_W'($urandom_range(0, 15));
        end
      endcase
      settle();
      write_setting(ph_tbits, ph_lg2);
      foreach (hot_bkts[k]) hot_bkts[k] = BUCKET_W'($urandom_range(0, live_buckets() - 1));
      foreach (tag_pool[k]) tag_pool[k] = TAG_W'({$urandom, $urandom}) & width_mask(ph_tbits);

      // phase 4 backs the block up: receiver holds off, sender never pauses
      sender_eager = (ph == 2) || (ph == 4);
      if (ph == 4) rx_hold_req = 1'b1;

      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        offer(draw_request(), 1'b0, '0, n == ITEMS_PER_PHASE - 1);
    end

    settle();
    $display("covered %0d request items over %0d register settings", items_sent, settings_used);
    $display("  %0d evictions, %0d find hits, %0d error results", evictions, find_hits,
             error_items);
    if (mismatch_cnt == 0 && pending_outcomes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (clearing pass, hold-off,
  // worst gaps and stalls on every item)
  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: sim.f
sv/cfft_pkg.sv
sv/cfft_ram.sv
sv/cfft_ctrl.sv
sv/cfft_dp.sv
sv/cuckoo_filter_tag_table_unit.sv
tb/cuckoo_filter_tag_table_unit_tb.sv
